/* design/ps2_mouse_packet_cursor_tracker_defines.svh */
// Assertion macros shared by the PS/2 cursor tracker RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef PS2_MOUSE_PACKET_CURSOR_TRACKER_DEFINES_SVH
`define PS2_MOUSE_PACKET_CURSOR_TRACKER_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define PS2M_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ps2m assertion failed");

// Next-cycle implication, disabled while in reset
`define PS2M_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ps2m assertion failed");

`endif

/* design/ps2m_pkg.sv */
// Shared types and constants for the PS/2 mouse cursor tracker.
// No dependencies; imported by every module of the block.
`default_nettype none

package ps2m_pkg;

    localparam int COORD_WIDTH_DEF = 12;
    localparam int BOUND_W         = 13;
    localparam int NEW_POS_W       = 13;
    localparam int DELTA_W         = 9;
    localparam int DELTA_Y_W       = 10;
    localparam int CFG_IDX_W       = 1;

    localparam logic [BOUND_W-1:0] WIDTH_INIT  = 13'd800;
    localparam logic [BOUND_W-1:0] HEIGHT_INIT = 13'd600;
    localparam int CURSOR_X_INIT = 400;
    localparam int CURSOR_Y_INIT = 300;

    // Flag byte bit positions
    localparam int FLAG_SYNC_BIT  = 3;
    localparam int FLAG_XSIGN_BIT = 4;
    localparam int FLAG_YSIGN_BIT = 5;
    localparam int FLAG_XOVF_BIT  = 6;
    localparam int FLAG_YOVF_BIT  = 7;

    typedef enum logic [1:0] {
        KIND_RX_BYTE = 2'd0,
        KIND_SET_POS = 2'd1,
        KIND_CLEAR   = 2'd2,
        KIND_NONE    = 2'd3
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SCREEN_WIDTH  = 1'b0,
        REG_SCREEN_HEIGHT = 1'b1
    } t_reg_idx;

    typedef enum logic [1:0] {
        POS_FLAG = 2'd0,
        POS_X    = 2'd1,
        POS_Y    = 2'd2
    } t_byte_pos;

    // Decoded packet status from the assembler to the tracker datapath
    typedef struct packed {
        logic               done;
        logic               drop;
        logic [2:0]         buttons;
        logic [DELTA_W-1:0] dx;
        logic [DELTA_W-1:0] dy;
    } t_pkt;

endpackage

`default_nettype wire

/* design/ps2m_pkt_asm.sv */
// Three-byte PS/2 packet assembler: sync on the flag byte, decode deltas.
// Depends on ps2m_pkg.
`default_nettype none

module ps2m_pkt_asm (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_fire,
    input  wire ps2m_pkg::t_kind i_kind,
    input  wire logic [7:0]      i_data,
    output ps2m_pkg::t_pkt       o_pkt
);
    import ps2m_pkg::*;

    t_byte_pos  r_pos, n_pos;
    logic [7:0] r_flag, n_flag;
    logic [7:0] r_xbyte, n_xbyte;
    logic       rx;
    logic       ovf;

    assign rx  = i_fire && (i_kind == KIND_RX_BYTE);
    assign ovf = r_flag[FLAG_XOVF_BIT] || r_flag[FLAG_YOVF_BIT];

    // next state
    always_comb begin
        n_pos   = r_pos;
        n_flag  = r_flag;
        n_xbyte = r_xbyte;
        if (rx) begin
            unique case (r_pos)
                POS_FLAG: begin
                    // out of sync bytes are thrown away here
                    if (i_data[FLAG_SYNC_BIT]) begin
                        n_flag = i_data;
                        n_pos  = POS_X;
                    end
                end
                POS_X: begin
                    n_xbyte = i_data;
                    n_pos   = POS_Y;
                end
                POS_Y:   n_pos = POS_FLAG;
                default: n_pos = POS_FLAG;
            endcase
        end
    end

    // outputs
    always_comb begin
        o_pkt.done    = 1'b0;
        o_pkt.drop    = 1'b0;
        o_pkt.buttons = r_flag[2:0];
        o_pkt.dx      = {r_flag[FLAG_XSIGN_BIT], r_xbyte};
        o_pkt.dy      = {r_flag[FLAG_YSIGN_BIT], i_data};
        unique case (r_pos)
            POS_Y: begin
                o_pkt.done = (i_kind == KIND_RX_BYTE) && !ovf;
                o_pkt.drop = (i_kind == KIND_RX_BYTE) && ovf;
            end
            default: begin
                o_pkt.done = 1'b0;
                o_pkt.drop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= POS_FLAG;
            r_flag  <= '0;
            r_xbyte <= '0;
        end else begin
            r_pos   <= n_pos;
            r_flag  <= n_flag;
            r_xbyte <= n_xbyte;
        end
    end

endmodule

`default_nettype wire

/* design/ps2m_axis_clamp.sv */
// Clamps a signed coordinate to [0, min(bound - 1, 2^COORD_WIDTH - 1)].
// Depends on ps2m_pkg.
`default_nettype none

module ps2m_axis_clamp #(
    parameter int COORD_WIDTH = ps2m_pkg::COORD_WIDTH_DEF,
    parameter int VAL_WIDTH   = 15
) (
    input  wire logic signed [VAL_WIDTH-1:0]        i_value,
    input  wire logic [ps2m_pkg::BOUND_W-1:0]       i_bound,
    output logic [COORD_WIDTH-1:0]                  o_coord
);
    import ps2m_pkg::*;

    localparam logic signed [VAL_WIDTH-1:0] CMAX = VAL_WIDTH'((1 << COORD_WIDTH) - 1);

    logic [BOUND_W-1:0]          bound_m1;
    logic signed [VAL_WIDTH-1:0] bound_ext;
    logic signed [VAL_WIDTH-1:0] hi;

    // a zero bound behaves as a bound of one
    assign bound_m1  = (i_bound == '0) ? '0 : i_bound - 1'b1;
    assign bound_ext = $signed({{(VAL_WIDTH-BOUND_W){1'b0}}, bound_m1});
    assign hi        = (bound_ext > CMAX) ? CMAX : bound_ext;

    always_comb begin
        if (i_value < 0) begin
            o_coord = '0;
        end else if (i_value > hi) begin
            o_coord = hi[COORD_WIDTH-1:0];
        end else begin
            o_coord = i_value[COORD_WIDTH-1:0];
        end
    end

endmodule

`default_nettype wire

/* design/ps2_mouse_packet_cursor_tracker.sv */
// PS/2 mouse packet decoder and cursor tracker, top level.
// Depends on ps2m_pkg, ps2m_pkt_asm, ps2m_axis_clamp and the defines header.
//
// Input channel (i_in_valid/o_in_ready): one transaction per received byte,
// set-position request or mark clear. Output channel (o_out_valid/i_out_ready):
// exactly one result transaction per input transaction, in order.
// Config channel (i_cfg_valid/o_cfg_ready): always ready; index 0 writes the
// screen width, index 1 the screen height, and the cursor is re-clamped at once.
// Write config only while no transaction is in flight.
// A result passes through the input register, which loads when its input is
// accepted, and then the result register, which loads when the result slot is free.
// Throughput: one transaction per cycle while the receiver does not stall, set by
// the single add-and-clamp step per axis between the registers.
// When the receiver stalls, the result register holds and the input register
// fills; input ready drops only when both are full.
// Reset (synchronous, active low): packet sync lost, buttons and marks clear,
// bounds 800 x 600, cursor at 400, 300 (limited to the coordinate range).
`default_nettype none
`include "ps2_mouse_packet_cursor_tracker_defines.svh"

module ps2_mouse_packet_cursor_tracker #(
    parameter int COORD_WIDTH = ps2m_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_in_valid,
    output logic                                        o_in_ready,
    input  wire logic [1:0]                             i_kind,
    input  wire logic [7:0]                             i_data_byte,
    input  wire logic signed [ps2m_pkg::NEW_POS_W-1:0]  i_new_x,
    input  wire logic signed [ps2m_pkg::NEW_POS_W-1:0]  i_new_y,
    output logic                                        o_out_valid,
    input  wire logic                                   i_out_ready,
    output logic [COORD_WIDTH-1:0]                      o_pos_x,
    output logic [COORD_WIDTH-1:0]                      o_pos_y,
    output logic [2:0]                                  o_buttons,
    output logic signed [ps2m_pkg::DELTA_W-1:0]         o_delta_x,
    output logic signed [ps2m_pkg::DELTA_Y_W-1:0]       o_delta_y,
    output logic                                        o_moved,
    output logic                                        o_btn_changed,
    output logic                                        o_event_res,
    output logic                                        o_dropped,
    input  wire logic                                   i_cfg_valid,
    output logic                                        o_cfg_ready,
    input  wire logic [ps2m_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  wire logic [ps2m_pkg::BOUND_W-1:0]           i_cfg_data
);
    import ps2m_pkg::*;

    localparam int VW   = ((COORD_WIDTH > BOUND_W) ? COORD_WIDTH : BOUND_W) + 2;
    localparam int CMAX = (1 << COORD_WIDTH) - 1;
    localparam logic [COORD_WIDTH-1:0] RST_X =
        COORD_WIDTH'((CURSOR_X_INIT > CMAX) ? CMAX : CURSOR_X_INIT);
    localparam logic [COORD_WIDTH-1:0] RST_Y =
        COORD_WIDTH'((CURSOR_Y_INIT > CMAX) ? CMAX : CURSOR_Y_INIT);

    // input register
    logic                        r_s1_valid;
    t_kind                       r_s1_kind;
    logic [7:0]                  r_s1_data;
    logic signed [NEW_POS_W-1:0] r_s1_new_x;
    logic signed [NEW_POS_W-1:0] r_s1_new_y;

    // tracker state
    logic [BOUND_W-1:0]     r_width, n_width;
    logic [BOUND_W-1:0]     r_height, n_height;
    logic [COORD_WIDTH-1:0] r_cursor_x, n_cursor_x;
    logic [COORD_WIDTH-1:0] r_cursor_y, n_cursor_y;
    logic [2:0]             r_btn, n_btn;
    logic [DELTA_W-1:0]     r_last_dx, n_last_dx;
    logic [DELTA_Y_W-1:0]   r_last_dy, n_last_dy;
    logic                   r_moved, n_moved;
    logic                   r_changed, n_changed;
    logic                   n_event;

    // result register
    logic                   r_out_valid;
    logic [COORD_WIDTH-1:0] r_out_x;
    logic [COORD_WIDTH-1:0] r_out_y;
    logic [2:0]             r_out_btn;
    logic [DELTA_W-1:0]     r_out_dx;
    logic [DELTA_Y_W-1:0]   r_out_dy;
    logic                   r_out_moved;
    logic                   r_out_changed;
    logic                   r_out_event;
    logic                   r_out_dropped;

    logic                   in_fire;
    logic                   s2_fire;
    logic                   cfg_fire;
    logic                   cfg_wr_x;
    logic                   cfg_wr_y;
    t_pkt                   pkt;
    logic                   pkt_moves;
    logic signed [VW-1:0]   cur_x_ext;
    logic signed [VW-1:0]   cur_y_ext;
    logic signed [VW-1:0]   clamp_in_x;
    logic signed [VW-1:0]   clamp_in_y;
    logic [BOUND_W-1:0]     bound_x;
    logic [BOUND_W-1:0]     bound_y;
    logic [COORD_WIDTH-1:0] clamped_x;
    logic [COORD_WIDTH-1:0] clamped_y;

    assign s2_fire    = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s2_fire;
    assign in_fire    = i_in_valid && o_in_ready;

    assign o_cfg_ready = 1'b1;
    assign cfg_fire    = i_cfg_valid && o_cfg_ready;
    assign cfg_wr_x    = cfg_fire && (t_reg_idx'(i_cfg_index) == REG_SCREEN_WIDTH);
    assign cfg_wr_y    = cfg_fire && (t_reg_idx'(i_cfg_index) == REG_SCREEN_HEIGHT);

    ps2m_pkt_asm u_pkt_asm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (s2_fire),
        .i_kind  (r_s1_kind),
        .i_data  (r_s1_data),
        .o_pkt   (pkt)
    );

    assign pkt_moves = (pkt.dx != '0) || (pkt.dy != '0);
    assign cur_x_ext = $signed({{(VW-COORD_WIDTH){1'b0}}, r_cursor_x});
    assign cur_y_ext = $signed({{(VW-COORD_WIDTH){1'b0}}, r_cursor_y});

    // One clamp per axis, shared by movement, set-position and bound writes.
    // PS/2 Y points up, so the screen Y takes minus the received delta.
    always_comb begin
        if (cfg_wr_x) begin
            clamp_in_x = cur_x_ext;
        end else if (r_s1_kind == KIND_SET_POS) begin
            clamp_in_x = {{(VW-NEW_POS_W){r_s1_new_x[NEW_POS_W-1]}}, r_s1_new_x};
        end else begin
            clamp_in_x = cur_x_ext + $signed({{(VW-DELTA_W){pkt.dx[DELTA_W-1]}}, pkt.dx});
        end
        if (cfg_wr_y) begin
            clamp_in_y = cur_y_ext;
        end else if (r_s1_kind == KIND_SET_POS) begin
            clamp_in_y = {{(VW-NEW_POS_W){r_s1_new_y[NEW_POS_W-1]}}, r_s1_new_y};
        end else begin
            clamp_in_y = cur_y_ext - $signed({{(VW-DELTA_W){pkt.dy[DELTA_W-1]}}, pkt.dy});
        end
    end

    assign bound_x = cfg_wr_x ? i_cfg_data : r_width;
    assign bound_y = cfg_wr_y ? i_cfg_data : r_height;

    ps2m_axis_clamp #(
        .COORD_WIDTH (COORD_WIDTH),
        .VAL_WIDTH   (VW)
    ) u_clamp_x (
        .i_value (clamp_in_x),
        .i_bound (bound_x),
        .o_coord (clamped_x)
    );

    ps2m_axis_clamp #(
        .COORD_WIDTH (COORD_WIDTH),
        .VAL_WIDTH   (VW)
    ) u_clamp_y (
        .i_value (clamp_in_y),
        .i_bound (bound_y),
        .o_coord (clamped_y)
    );

    always_comb begin
        n_width    = cfg_wr_x ? i_cfg_data : r_width;
        n_height   = cfg_wr_y ? i_cfg_data : r_height;
        n_cursor_x = r_cursor_x;
        n_cursor_y = r_cursor_y;
        n_btn      = r_btn;
        n_last_dx  = r_last_dx;
        n_last_dy  = r_last_dy;
        n_moved    = r_moved;
        n_changed  = r_changed;
        n_event    = 1'b0;
        if (s2_fire) begin
            case (r_s1_kind)
                KIND_RX_BYTE: begin
                    if (pkt.done) begin
                        if (pkt.buttons != r_btn) begin
                            n_changed = 1'b1;
                        end
                        n_btn = pkt.buttons;
                        if (pkt_moves) begin
                            n_last_dx  = pkt.dx;
                            n_last_dy  = -{pkt.dy[DELTA_W-1], pkt.dy};
                            n_cursor_x = clamped_x;
                            n_cursor_y = clamped_y;
                            n_moved    = 1'b1;
                        end
                        n_event = n_moved || n_changed;
                    end
                end
                KIND_SET_POS: begin
                    n_cursor_x = clamped_x;
                    n_cursor_y = clamped_y;
                end
                KIND_CLEAR: begin
                    n_moved   = 1'b0;
                    n_changed = 1'b0;
                    n_last_dx = '0;
                    n_last_dy = '0;
                end
                default: n_event = 1'b0;
            endcase
        end else begin
            // bound write re-clamps the cursor on that axis
            if (cfg_wr_x) begin
                n_cursor_x = clamped_x;
            end
            if (cfg_wr_y) begin
                n_cursor_y = clamped_y;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_width     <= WIDTH_INIT;
            r_height    <= HEIGHT_INIT;
            r_cursor_x  <= RST_X;
            r_cursor_y  <= RST_Y;
            r_btn       <= '0;
            r_last_dx   <= '0;
            r_last_dy   <= '0;
            r_moved     <= 1'b0;
            r_changed   <= 1'b0;
        end else begin
            if (in_fire) begin
                r_s1_valid <= 1'b1;
            end else if (s2_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (s2_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            r_width    <= n_width;
            r_height   <= n_height;
            r_cursor_x <= n_cursor_x;
            r_cursor_y <= n_cursor_y;
            r_btn      <= n_btn;
            r_last_dx  <= n_last_dx;
            r_last_dy  <= n_last_dy;
            r_moved    <= n_moved;
            r_changed  <= n_changed;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_kind  <= t_kind'(i_kind);
            r_s1_data  <= i_data_byte;
            r_s1_new_x <= i_new_x;
            r_s1_new_y <= i_new_y;
        end
        if (s2_fire) begin
            r_out_x       <= n_cursor_x;
            r_out_y       <= n_cursor_y;
            r_out_btn     <= n_btn;
            r_out_dx      <= n_last_dx;
            r_out_dy      <= n_last_dy;
            r_out_moved   <= n_moved;
            r_out_changed <= n_changed;
            r_out_event   <= n_event;
            r_out_dropped <= pkt.drop;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_pos_x       = r_out_x;
    assign o_pos_y       = r_out_y;
    assign o_buttons     = r_out_btn;
    assign o_delta_x     = $signed(r_out_dx);
    assign o_delta_y     = $signed(r_out_dy);
    assign o_moved       = r_out_moved;
    assign o_btn_changed = r_out_changed;
    assign o_event_res   = r_out_event;
    assign o_dropped     = r_out_dropped;

    `PS2M_ASSERT_IMPL(a_x_in_bounds, i_clk, i_rst_n, r_width != '0, VW'(r_cursor_x) < VW'(r_width))
    `PS2M_ASSERT_IMPL(a_y_in_bounds, i_clk, i_rst_n, r_height != '0, VW'(r_cursor_y) < VW'(r_height))
    `PS2M_ASSERT_IMPL(a_event_marks, i_clk, i_rst_n, r_out_valid && r_out_event, r_out_moved || r_out_changed)
    `PS2M_ASSERT_IMPL(a_drop_no_event, i_clk, i_rst_n, r_out_valid && r_out_dropped, !r_out_event)
    `PS2M_ASSERT_NEXT(a_s1_holds, i_clk, i_rst_n, r_s1_valid && !s2_fire, r_s1_valid)

endmodule

`default_nettype wire

/* sim/ps2_mouse_packet_cursor_tracker_test.sv */
// Self-checking bench for the PS/2 mouse packet decoder and cursor tracker.
// Needs ps2m_pkg and the tracker RTL; a built-in cursor model scores every result
// across directed cases, a series of screen bound settings and random mouse traffic.
module ps2_mouse_packet_cursor_tracker_test;

    import ps2m_pkg::*;

    localparam int CW             = COORD_WIDTH_DEF;
    localparam int NUM_DIR        = 26;
    localparam int NUM_PHASES     = 11;
    localparam int ITEMS_PER_PHASE = 152;
    localparam int QUIET_LIMIT    = 1000;
    localparam int NUM_FIELDS     = 9;

    typedef struct packed {
        logic [CW-1:0]        pos_x;
        logic [CW-1:0]        pos_y;
        logic [2:0]           buttons;
        logic [DELTA_W-1:0]   delta_x;
        logic [DELTA_Y_W-1:0] delta_y;
        logic                 moved;
        logic                 changed;
        logic                 evt;
        logic                 dropped;
    } cursor_report_t;

    typedef struct packed {
        t_kind                kind;
        logic [7:0]           data;
        logic [NEW_POS_W-1:0] nx;
        logic [NEW_POS_W-1:0] ny;
        logic                 typed;
    } dir_row_t;

    // state straight after reset, before any packet lands
    localparam cursor_report_t HOME_REPORT = '{
        pos_x: CW'(CURSOR_X_INIT), pos_y: CW'(CURSOR_Y_INIT), default: '0};

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic [1:0]           i_kind      = '0;
    logic [7:0]           i_data_byte = '0;
    logic [NEW_POS_W-1:0] i_new_x     = '0;
    logic [NEW_POS_W-1:0] i_new_y     = '0;
    logic                 i_out_ready = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [BOUND_W-1:0]   i_cfg_data  = '0;

    logic                 o_in_ready;
    logic                 o_out_valid;
    logic [CW-1:0]        o_pos_x;
    logic [CW-1:0]        o_pos_y;
    logic [2:0]           o_buttons;
    logic [DELTA_W-1:0]   o_delta_x;
    logic [DELTA_Y_W-1:0] o_delta_y;
    logic                 o_moved;
    logic                 o_btn_changed;
    logic                 o_event_res;
    logic                 o_dropped;
    logic                 o_cfg_ready;

    ps2_mouse_packet_cursor_tracker DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_kind           (i_kind),
        .i_data_byte      (i_data_byte),
        .i_new_x          (i_new_x),
        .i_new_y          (i_new_y),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_pos_x          (o_pos_x),
        .o_pos_y          (o_pos_y),
        .o_buttons        (o_buttons),
        .o_delta_x        (o_delta_x),
        .o_delta_y        (o_delta_y),
        .o_moved          (o_moved),
        .o_btn_changed    (o_btn_changed),
        .o_event_res      (o_event_res),
        .o_dropped        (o_dropped),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Cursor model state
    t_byte_pos          asm_pos;
    logic [7:0]         asm_flags;
    logic [7:0]         asm_xbyte;
    logic [CW-1:0]      cur_x;
    logic [CW-1:0]      cur_y;
    logic [2:0]         btn;
    logic [DELTA_W-1:0] last_dx;
    logic [DELTA_Y_W-1:0] last_dy;
    logic               moved_f;
    logic               changed_f;
    logic [BOUND_W-1:0] bnd_w;
    logic [BOUND_W-1:0] bnd_h;

    cursor_report_t cursor_reports_q[$];

    bit idling = 1'b1;
    int hold_left = 0;
    int n_err = 0;
    int n_items = 0;
    int n_checked = 0;
    int n_packets = 0;
    int n_drops = 0;
    int n_cfg = 0;

    string field_name [0:NUM_FIELDS-1] = '{"pos_x", "pos_y", "buttons", "delta_x",
        "delta_y", "moved", "btn_changed", "event_res", "dropped"};

    dir_row_t dir_tbl [0:NUM_DIR-1] = '{
        '{KIND_NONE,    8'h00, 13'h0000, 13'h0000, 1'b1},
        '{KIND_RX_BYTE, 8'h00, 13'h1FFF, 13'h1FFF, 1'b1},  // sync bit clear
        '{KIND_RX_BYTE, 8'hF7, 13'h0000, 13'h0000, 1'b1},  // sync bit clear, rest set
        '{KIND_RX_BYTE, 8'h08, 13'h0000, 13'h0000, 1'b1},
        '{KIND_RX_BYTE, 8'h7F, 13'h0000, 13'h0000, 1'b1},
        '{KIND_RX_BYTE, 8'h00, 13'h0000, 13'h0000, 1'b0},
        '{KIND_RX_BYTE, 8'h3F, 13'h0000, 13'h0000, 1'b0},  // all buttons, both signs
        '{KIND_RX_BYTE, 8'h00, 13'h0000, 13'h0000, 1'b0},
        '{KIND_RX_BYTE, 8'h00, 13'h0000, 13'h0000, 1'b0},
        '{KIND_RX_BYTE, 8'h08, 13'h0000, 13'h0000, 1'b0},
        '{KIND_RX_BYTE, 8'hFF, 13'h0000, 13'h0000, 1'b0},
        '{KIND_RX_BYTE, 8'hFF, 13'h0000, 13'h0000, 1'b0},
        '{KIND_RX_BYTE, 8'h48, 13'h0000, 13'h0000, 1'b0},  // X overflow
        '{KIND_RX_BYTE, 8'h12, 13'h0000, 13'h0000, 1'b0},
        '{KIND_RX_BYTE, 8'h34, 13'h0000, 13'h0000, 1'b0},
        '{KIND_RX_BYTE, 8'h88, 13'h0000, 13'h0000, 1'b0},  // Y overflow
        '{KIND_RX_BYTE, 8'h56, 13'h0000, 13'h0000, 1'b0},
        '{KIND_RX_BYTE, 8'h78, 13'h0000, 13'h0000, 1'b0},
        '{KIND_SET_POS, 8'hA5, 13'h1000, 13'h1000, 1'b0},
        '{KIND_SET_POS, 8'h5A, 13'h0FFF, 13'h0FFF, 1'b0},
        '{KIND_CLEAR,   8'h00, 13'h0000, 13'h0000, 1'b0},
        '{KIND_RX_BYTE, 8'h1F, 13'h0000, 13'h0000, 1'b0},
        '{KIND_SET_POS, 8'h00, 13'h0000, 13'h0000, 1'b0},  // mid-packet
        '{KIND_RX_BYTE, 8'hFF, 13'h0000, 13'h0000, 1'b0},
        '{KIND_CLEAR,   8'h00, 13'h0000, 13'h0000, 1'b0},  // mid-packet
        '{KIND_RX_BYTE, 8'h01, 13'h0000, 13'h0000, 1'b0}
    };

    function automatic logic [CW-1:0] clamp_axis(int v, logic [BOUND_W-1:0] bound);
        int hi;
        hi = (bound == 0) ? 0 : int'(bound) - 1;
        if (hi > (1 << CW) - 1) hi = (1 << CW) - 1;
        if (v < 0) v = 0;
        if (v > hi) v = hi;
        return CW'(v);
    endfunction

    function automatic logic [11:0] field_of(cursor_report_t r, int i);
        case (i)
            0:       return 12'(r.pos_x);
            1:       return 12'(r.pos_y);
            2:       return 12'(r.buttons);
            3:       return 12'(r.delta_x);
            4:       return 12'(r.delta_y);
            5:       return 12'(r.moved);
            6:       return 12'(r.changed);
            7:       return 12'(r.evt);
            default: return 12'(r.dropped);
        endcase
    endfunction

    function automatic logic [NEW_POS_W-1:0] rnd_coord();
        case ($urandom_range(0, 7))
            0:       return 13'h1000;
            1:       return 13'h0FFF;
            2:       return 13'h0000;
            3:       return 13'h1FFF;
            default: return 13'($urandom);
        endcase
    endfunction

    task automatic home_tracker();
        asm_pos   = POS_FLAG;
        asm_flags = '0;
        asm_xbyte = '0;
        bnd_w     = WIDTH_INIT;
        bnd_h     = HEIGHT_INIT;
        cur_x     = clamp_axis(CURSOR_X_INIT, bnd_w);
        cur_y     = clamp_axis(CURSOR_Y_INIT, bnd_h);
        btn       = '0;
        last_dx   = '0;
        last_dy   = '0;
        moved_f   = 1'b0;
        changed_f = 1'b0;
    endtask

    task automatic track_cursor(input t_kind k, input logic [7:0] d,
                                input logic [NEW_POS_W-1:0] nx, input logic [NEW_POS_W-1:0] ny,
                                output cursor_report_t r);
        int dx;
        int dy;
        logic evt;
        logic drop;
        evt  = 1'b0;
        drop = 1'b0;
        case (k)
            KIND_RX_BYTE: begin
                case (asm_pos)
                    POS_FLAG: begin
                        // bytes without the sync bit are skipped until a flag byte turns up
                        if (d[FLAG_SYNC_BIT]) begin
                            asm_flags = d;
                            asm_pos   = POS_X;
                        end
                    end
                    POS_X: begin
                        asm_xbyte = d;
                        asm_pos   = POS_Y;
                    end
                    default: begin
                        asm_pos = POS_FLAG;
                        n_packets++;
                        if (asm_flags[FLAG_XOVF_BIT] || asm_flags[FLAG_YOVF_BIT]) begin
                            drop = 1'b1;
                            n_drops++;
                        end else begin
                            dx = int'(asm_xbyte) - (asm_flags[FLAG_XSIGN_BIT] ? 256 : 0);
                            dy = int'(d) - (asm_flags[FLAG_YSIGN_BIT] ? 256 : 0);
                            if (asm_flags[2:0] != btn) changed_f = 1'b1;
                            btn = asm_flags[2:0];
                            if (dx != 0 || dy != 0) begin
                                // mouse Y points up, screen Y points down
                                last_dx = DELTA_W'(dx);
                                last_dy = DELTA_Y_W'(-dy);
                                cur_x   = clamp_axis(int'(cur_x) + dx, bnd_w);
                                cur_y   = clamp_axis(int'(cur_y) - dy, bnd_h);
                                moved_f = 1'b1;
                            end
                            evt = moved_f || changed_f;
                        end
                    end
                endcase
            end
            KIND_SET_POS: begin
                cur_x = clamp_axis(int'($signed(nx)), bnd_w);
                cur_y = clamp_axis(int'($signed(ny)), bnd_h);
            end
            KIND_CLEAR: begin
                moved_f   = 1'b0;
                changed_f = 1'b0;
                last_dx   = '0;
                last_dy   = '0;
            end
            default: ;
        endcase
        r = '{cur_x, cur_y, btn, last_dx, last_dy, moved_f, changed_f, evt, drop};
    endtask

    task automatic report_mismatch(input string what);
        n_err++;
        if (n_err <= 30) $display("mismatch at %0t: %s", $time, what);
    endtask

    task automatic check_report();
        cursor_report_t got;
        cursor_report_t want;
        got = '{o_pos_x, o_pos_y, o_buttons, o_delta_x, o_delta_y, o_moved,
                o_btn_changed, o_event_res, o_dropped};
        if (cursor_reports_q.size() == 0) begin
            report_mismatch("result transaction with nothing outstanding");
            return;
        end
        want = cursor_reports_q.pop_front();
        for (int i = 0; i < NUM_FIELDS; i++)
            if (field_of(got, i) !== field_of(want, i))
                report_mismatch($sformatf("result %0d %s: got %0h, want %0h", n_checked,
                    field_name[i], field_of(got, i), field_of(want, i)));
        n_checked++;
    endtask

    // Receiver side: score each transaction, stall in short random bursts
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) check_report();
            if (hold_left != 0) begin
                hold_left   <= hold_left - 1;
                i_out_ready <= 1'b0;
            end else if (idling && $urandom_range(0, 9) == 0) begin
                hold_left   <= $urandom_range(0, 5);
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    task automatic send_item(input t_kind k, input logic [7:0] d,
                             input logic [NEW_POS_W-1:0] nx, input logic [NEW_POS_W-1:0] ny,
                             input bit typed = 1'b0);
        cursor_report_t r;
        if (idling && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_kind      <= k;
        i_data_byte <= d;
        i_new_x     <= nx;
        i_new_y     <= ny;
        do @(posedge i_clk); while (!o_in_ready);
        track_cursor(k, d, nx, ny, r);
        cursor_reports_q.push_back(typed ? HOME_REPORT : r);
        n_items++;
    endtask

    task automatic write_bound(input t_reg_idx idx, input logic [BOUND_W-1:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        // a new bound pulls the cursor back inside at once
        if (idx == REG_SCREEN_WIDTH) begin
            bnd_w = v;
            cur_x = clamp_axis(int'(cur_x), bnd_w);
        end else begin
            bnd_h = v;
            cur_y = clamp_axis(int'(cur_y), bnd_h);
        end
        n_cfg++;
    endtask

    task automatic drain_reports();
        i_in_valid <= 1'b0;
        while (cursor_reports_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic interrupt_packet();
        case ($urandom_range(0, 27))
            0:       send_item(KIND_SET_POS, 8'($urandom), rnd_coord(), rnd_coord());
            1:       send_item(KIND_CLEAR, 8'($urandom), rnd_coord(), rnd_coord());
            default: ;
        endcase
    endtask

    task automatic send_packet();
        logic [7:0] flags;
        logic [7:0] xb;
        logic [7:0] yb;
        flags = 8'($urandom);
        flags[FLAG_SYNC_BIT] = 1'b1;
        if ($urandom_range(0, 9) != 0) begin
            flags[FLAG_XOVF_BIT] = 1'b0;
            flags[FLAG_YOVF_BIT] = 1'b0;
        end
        xb = 8'($urandom);
        yb = 8'($urandom);
        if ($urandom_range(0, 7) == 0) begin
            // buttons only, no movement
            xb = '0;
            yb = '0;
            flags[FLAG_XSIGN_BIT] = 1'b0;
            flags[FLAG_YSIGN_BIT] = 1'b0;
        end
        send_item(KIND_RX_BYTE, flags, rnd_coord(), rnd_coord());
        interrupt_packet();
        send_item(KIND_RX_BYTE, xb, rnd_coord(), rnd_coord());
        interrupt_packet();
        send_item(KIND_RX_BYTE, yb, rnd_coord(), rnd_coord());
    endtask

    task automatic send_mouse_traffic(input int n);
        int start;
        int sel;
        start = n_items;
        while (n_items - start < n) begin
            sel = $urandom_range(0, 99);
            if (sel < 72) begin
                send_packet();
            end else if (sel < 84) begin
                send_item(KIND_SET_POS, 8'($urandom), rnd_coord(), rnd_coord());
            end else if (sel < 90) begin
                send_item(KIND_CLEAR, 8'($urandom), rnd_coord(), rnd_coord());
            end else if (sel < 94) begin
                send_item(KIND_NONE, 8'($urandom), rnd_coord(), rnd_coord());
            end else begin
                // stray byte: may knock the assembler out of step
                send_item(KIND_RX_BYTE, 8'($urandom), rnd_coord(), rnd_coord());
            end
        end
    endtask

    task automatic pick_bounds(input int ph, output logic [BOUND_W-1:0] w,
                               output logic [BOUND_W-1:0] h);
        case (ph)
            1:  begin w = 13'd0;    h = 13'd8191; end
            2:  begin w = 13'd8191; h = 13'd0;    end
            3:  begin w = 13'd4096; h = 13'd4096; end
            4:  begin w = 13'd1;    h = 13'd1;    end
            5:  begin w = 13'd4097; h = 13'd4095; end
            6:  begin w = 13'h1555; h = 13'h0AAA; end
            NUM_PHASES: begin w = WIDTH_INIT; h = HEIGHT_INIT; end
            default: begin
                w = ($urandom_range(0, 1) != 0) ? 13'($urandom_range(1, 64))
                                                : 13'($urandom_range(1, 4096));
                h = ($urandom_range(0, 1) != 0) ? 13'($urandom_range(1, 64))
                                                : 13'($urandom_range(1, 4096));
            end
        endcase
    endtask

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                    || (i_cfg_valid && o_cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("stalled: no transaction for %0d cycles", QUIET_LIMIT);
        $display("FAIL");
        $finish;
    end

    initial begin : stimulus
        logic [BOUND_W-1:0] w;
        logic [BOUND_W-1:0] h;
        home_tracker();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < NUM_DIR; i++)
            send_item(dir_tbl[i].kind, dir_tbl[i].data, dir_tbl[i].nx, dir_tbl[i].ny,
                      dir_tbl[i].typed);

        for (int ph = 1; ph <= NUM_PHASES; ph++) begin
            drain_reports();
            pick_bounds(ph, w, h);
            write_bound(REG_SCREEN_WIDTH, w);
            write_bound(REG_SCREEN_HEIGHT, h);
            i_cfg_valid <= 1'b0;
            idling = (ph != NUM_PHASES);
            send_mouse_traffic(ITEMS_PER_PHASE);
        end

        drain_reports();
        repeat (8) @(posedge i_clk);

        $display("covered %0d input transactions over %0d bound settings (%0d bound writes)",
                 n_items, NUM_PHASES + 1, n_cfg);
        $display("%0d packets completed, %0d dropped for overflow, %0d results scored",
                 n_packets, n_drops, n_checked);
        if (n_err == 0 && cursor_reports_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("%0d mismatches, %0d results outstanding", n_err, cursor_reports_q.size());
            $display("FAIL");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+design
design/ps2m_pkg.sv
design/ps2m_pkt_asm.sv
design/ps2m_axis_clamp.sv
design/ps2_mouse_packet_cursor_tracker.sv
sim/ps2_mouse_packet_cursor_tracker_test.sv
